>>> design/mmsp_pkg.sv
// mmsp_pkg: types, codes and pattern helpers for the multipart splitter
// used by every module of the splitter; depends on nothing

package mmsp_pkg;

    localparam int MAX_BOUNDARY_BYTES = 32;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_NL   = 8'h0a;

    localparam logic [2:0] CFG_LENGTH = 3'd0;
    localparam logic [2:0] CFG_WORD0  = 3'd1;
    localparam logic [2:0] CFG_WORD1  = 3'd2;
    localparam logic [2:0] CFG_WORD2  = 3'd3;
    localparam logic [2:0] CFG_WORD3  = 3'd4;

    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_CLOSE   = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    localparam logic [1:0] SEG_PRE  = 2'd0;
    localparam logic [1:0] SEG_PART = 2'd1;
    localparam logic [1:0] SEG_EPI  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] segment;
        logic [7:0] part_number;
        logic       parts_found;
        logic       last_result;
    } t_out;

    typedef struct packed {
        logic [5:0]                 boundary_length;
        logic [3:0][7:0][7:0]       boundary_bytes;
    } t_cfg;

    // one queue entry: the results one word causes, in emit order
    typedef struct packed {
        logic [5:0] cnt_a;
        logic       has_byte;
        logic [7:0] data;
        logic       has_close;
        logic [5:0] cnt_b;
        logic       done;
        logic [1:0] segment;
        logic [7:0] part_number;
        logic       parts_found;
    } t_cmd;

    typedef enum logic [2:0] {
        PM_PRE      = 3'd0,
        PM_BODY     = 3'd1,
        PM_POST1    = 3'd2,
        PM_POST2    = 3'd3,
        PM_SKIP     = 3'd4,
        PM_SKIP_END = 3'd5,
        PM_EPILOGUE = 3'd6,
        PM_GIVEN_UP = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        PH_FLUSH_A = 3'd0,
        PH_BYTE    = 3'd1,
        PH_CLOSE   = 3'd2,
        PH_FLUSH_B = 3'd3,
        PH_DONE    = 3'd4,
        PH_IDLE    = 3'd5
    } t_phase;

    function automatic logic [5:0] pattern_len(input t_cfg cfg);
        logic [5:0] l;
        l = cfg.boundary_length;
        if (l == 6'd0) l = 6'd1;
        if (l > 6'(MAX_BOUNDARY_BYTES)) l = 6'(MAX_BOUNDARY_BYTES);
        return 6'(l + 6'd2);
    endfunction

    function automatic logic [7:0] pattern_byte(input t_cfg cfg, input logic [5:0] k);
        logic [5:0] i;
        logic [7:0] b;
        i = 6'(k - 6'd2);
        if (k < 6'd2) b = CH_DASH;
        else if (i[5]) b = 8'h00;
        else b = cfg.boundary_bytes[i[4:3]][i[2:0]];
        return b;
    endfunction

endpackage

>>> design/mmsp_front.sv
// mmsp_front: takes message words, tracks the boundary match and parse mode
// and pushes a result descriptor for each word that causes results; uses mmsp_pkg

module mmsp_front import mmsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    input  t_cfg i_cfg,
    input  logic i_full,
    output logic o_push,
    output t_cmd o_cmd
);

    t_mode      r_mode, n_mode;
    logic [5:0] r_mc, n_mc;
    logic       r_ls, n_ls;
    logic [7:0] r_pc, n_pc;

    logic [5:0] plen, mc;
    logic [7:0] c, pb_cur, pb_prev;
    logic       ls, restart, do_start, accept;
    t_cmd       cmd;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        c        = i_in_data.in_byte;
        plen     = pattern_len(i_cfg);
        mc       = (r_mc >= plen) ? 6'(plen - 6'd1) : r_mc;
        pb_cur   = pattern_byte(i_cfg, mc);
        pb_prev  = pattern_byte(i_cfg, 6'(mc - 6'd1));
        n_mode   = r_mode;
        n_mc     = r_mc;
        n_ls     = r_ls;
        n_pc     = r_pc;
        cmd      = '0;
        ls       = r_ls;
        restart  = 1'b0;
        do_start = 1'b0;
        case (r_mode)
            PM_PRE, PM_BODY: begin
                n_mc = mc;
                if (mc != 6'd0) begin
                    if (c == pb_cur) begin
                        if (6'(mc + 6'd1) == plen) begin
                            n_mc          = 6'd0;
                            cmd.has_close = (r_mode == PM_BODY);
                            n_mode        = PM_POST1;
                        end else begin
                            n_mc = 6'(mc + 6'd1);
                        end
                    end else begin
                        // mismatch: held bytes go out as content
                        cmd.cnt_a = mc;
                        ls        = (pb_prev == CH_NL);
                        n_mc      = 6'd0;
                        restart   = 1'b1;
                    end
                end else begin
                    restart = 1'b1;
                end
                if (restart) begin
                    if (ls && c == CH_DASH) begin
                        n_mc = 6'd1;
                        n_ls = 1'b0;
                    end else begin
                        cmd.has_byte = 1'b1;
                        cmd.data     = c;
                        n_ls         = (c == CH_NL);
                    end
                end
            end
            PM_POST1: begin
                if (c == CH_DASH) n_mode = PM_POST2;
                else if (c == CH_NL) do_start = 1'b1;
                else n_mode = PM_SKIP;
            end
            PM_POST2: begin
                if (c == CH_DASH) n_mode = (r_pc != 8'd0) ? PM_SKIP_END : PM_GIVEN_UP;
                else if (c == CH_NL) do_start = 1'b1;
                else n_mode = PM_SKIP;
            end
            PM_SKIP: begin
                if (c == CH_NL) do_start = 1'b1;
            end
            PM_SKIP_END: begin
                if (c == CH_NL) n_mode = PM_EPILOGUE;
            end
            PM_EPILOGUE: begin
                cmd.has_byte = 1'b1;
                cmd.data     = c;
            end
            default: begin
            end
        endcase

        if (do_start) begin
            n_pc   = (r_pc == 8'hff) ? r_pc : 8'(r_pc + 8'd1);
            n_mode = PM_BODY;
            n_mc   = 6'd0;
            n_ls   = 1'b1;
        end

        cmd.part_number = n_pc;
        if (n_mode inside {PM_SKIP_END, PM_EPILOGUE}) cmd.segment = SEG_EPI;
        else cmd.segment = (n_pc != 8'd0) ? SEG_PART : SEG_PRE;

        if (i_in_data.end_of_message) begin
            if (n_mode inside {PM_PRE, PM_BODY}) cmd.cnt_b = n_mc;
            cmd.done        = 1'b1;
            cmd.parts_found = (n_pc != 8'd0);
            n_mode          = PM_PRE;
            n_mc            = 6'd0;
            n_ls            = 1'b1;
            n_pc            = 8'd0;
        end

        o_cmd  = cmd;
        o_push = accept && (cmd.cnt_a != 6'd0 || cmd.has_byte || cmd.has_close ||
                            cmd.cnt_b != 6'd0 || cmd.done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= PM_PRE;
            r_mc   <= 6'd0;
            r_ls   <= 1'b1;
            r_pc   <= 8'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_mc   <= n_mc;
            r_ls   <= n_ls;
            r_pc   <= n_pc;
        end
    end

endmodule

>>> design/mmsp_queue.sv
// mmsp_queue: short descriptor queue between front and back
// uses mmsp_pkg for the descriptor type

module mmsp_queue import mmsp_pkg::*; #(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cmd          r_mem [P_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(P_DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
            if (do_pop)  r_rd <= (r_rd == AW'(P_DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
            if (do_push && !do_pop) r_cnt <= CW'(r_cnt + 1'b1);
            else if (do_pop && !do_push) r_cnt <= CW'(r_cnt - 1'b1);
        end
    end

endmodule

>>> design/mmsp_back.sv
// mmsp_back: expands queued descriptors into result words, one per cycle while
// the output is not stalled, through a registered output stage; uses mmsp_pkg

module mmsp_back import mmsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_cmd i_cmd,
    input  logic i_empty,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_phase     r_phase, n_phase, nxt;
    t_cmd       r_cmd, n_cmd;
    logic [5:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;

    logic       can_emit, emit, last, stay;
    t_out       res;

    function automatic t_phase first_phase(input t_cmd cmd, input t_phase from);
        t_phase p;
        p = PH_IDLE;
        if (cmd.done && from <= PH_DONE) p = PH_DONE;
        if (cmd.cnt_b != 6'd0 && from <= PH_FLUSH_B) p = PH_FLUSH_B;
        if (cmd.has_close && from <= PH_CLOSE) p = PH_CLOSE;
        if (cmd.has_byte && from <= PH_BYTE) p = PH_BYTE;
        if (cmd.cnt_a != 6'd0 && from <= PH_FLUSH_A) p = PH_FLUSH_A;
        return p;
    endfunction

    always_comb begin
        res             = '0;
        res.segment     = r_cmd.segment;
        res.part_number = r_cmd.part_number;
        stay            = 1'b0;
        case (r_phase)
            PH_FLUSH_A: begin
                res.kind     = KIND_CONTENT;
                res.out_byte = pattern_byte(i_cfg, r_idx);
                stay         = (6'(r_idx + 6'd1) < r_cmd.cnt_a);
            end
            PH_BYTE: begin
                res.kind     = KIND_CONTENT;
                res.out_byte = r_cmd.data;
            end
            PH_CLOSE: begin
                res.kind = KIND_CLOSE;
            end
            PH_FLUSH_B: begin
                res.kind     = KIND_CONTENT;
                res.out_byte = pattern_byte(i_cfg, r_idx);
                stay         = (6'(r_idx + 6'd1) < r_cmd.cnt_b);
            end
            PH_DONE: begin
                res.kind        = KIND_DONE;
                res.parts_found = r_cmd.parts_found;
            end
            default: begin
            end
        endcase
        if (stay) nxt = r_phase;
        else if (r_phase == PH_IDLE) nxt = PH_IDLE;
        else nxt = first_phase(r_cmd, t_phase'(r_phase + 3'd1));
        last            = (nxt == PH_IDLE);
        res.last_result = last;

        can_emit    = !r_out_valid || !i_out_stall;
        emit        = can_emit && (r_phase != PH_IDLE);
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;

        if (r_phase == PH_IDLE || (emit && last)) begin
            if (!i_empty) begin
                o_pop   = 1'b1;
                n_cmd   = i_cmd;
                n_phase = first_phase(i_cmd, PH_FLUSH_A);
                n_idx   = 6'd0;
            end else begin
                n_phase = PH_IDLE;
            end
        end else if (emit) begin
            n_phase = nxt;
            n_idx   = stay ? 6'(r_idx + 6'd1) : 6'd0;
        end

        if (can_emit) begin
            n_out_valid = emit;
            if (emit) n_out = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> design/mime_multipart_splitter_top.sv
// mime_multipart_splitter_top: boundary registers, front parser, descriptor
// queue and result expander; uses mmsp_pkg, mmsp_front, mmsp_queue, mmsp_back
//
//   channel | direction | handshake              | payload
//   in      | input     | i_in_valid/o_in_stall  | i_in_data (t_in)
//   out     | output    | o_out_valid/i_out_stall| o_out_data (t_out)
//   cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// the front takes one word per cycle while the descriptor queue has room
// a word with n results holds the expander for all n, one result per cycle
// unless the output stalls; a held-byte flush gives up to the boundary length
// plus one bytes; synchronous reset clears parse state, queue and boundary
// bytes and sets the boundary length to one; output stall freezes the output
// register; the queue then fills, raising o_in_stall at P_QUEUE_DEPTH entries

module mime_multipart_splitter_top import mmsp_pkg::*; #(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, pop, empty, full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boundary_length <= 6'd1;
            r_cfg.boundary_bytes  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LENGTH: r_cfg.boundary_length   <= i_cfg_data[5:0];
                CFG_WORD0:  r_cfg.boundary_bytes[0] <= i_cfg_data;
                CFG_WORD1:  r_cfg.boundary_bytes[1] <= i_cfg_data;
                CFG_WORD2:  r_cfg.boundary_bytes[2] <= i_cfg_data;
                CFG_WORD3:  r_cfg.boundary_bytes[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mmsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    mmsp_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    mmsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (head_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> design/mmsp_checker.sv
// mmsp_checker: port-level checks on the splitter result channel
// uses mmsp_pkg; bound to mime_multipart_splitter_top

module mmsp_checker import mmsp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed under stall");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_CONTENT |-> o_out_data.out_byte == 8'd0)
        else $error("non-content result carries a byte");

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.parts_found |-> o_out_data.kind == KIND_DONE)
        else $error("parts_found outside a done result");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_DONE |-> o_out_data.last_result)
        else $error("done result not marked last");

endmodule

bind mime_multipart_splitter_top mmsp_checker u_checker (.*);

>>> dv/mime_multipart_splitter_top_test.sv
// mime_multipart_splitter_top_test: self-checking bench for the multipart splitter,
// directed messages then random well-formed and broken ones under random stalls
// depends on mmsp_pkg and mime_multipart_splitter_top

module mime_multipart_splitter_top_test;
    import mmsp_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int END_WAIT     = 20_000;
    localparam int RANDOM_WORDS = 460;
    localparam int QUIET_FROM   = 400;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_LENGTH;
    logic [63:0] i_cfg_data  = '0;

    mime_multipart_splitter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state and boundary registers
    t_mode       pm;
    logic [5:0]  held;
    logic        ls;
    logic [7:0]  parts;
    logic [5:0]  bnd_len;
    logic [63:0] bnd_word [4];

    t_out        step_res [$];
    t_out        pending_results [$];
    t_out        want;
    string       bad_fields;

    logic [63:0] cfg_words [4];
    logic [7:0]  bnd_q [$];
    logic [7:0]  msg_q [$];
    bit          msg_eom;

    bit          idle_on = 1'b1;
    bit          quiet   = 1'b0;
    int          cycle_cnt;
    int          err_cnt;
    int          words_sent;
    int          msgs_done;
    int          results_checked;
    int          cfg_writes;
    int          settings_used;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= 30) $display("ERROR at %0t: %s", $time, what);
    endtask

    function automatic string fmt_result(input t_out r);
        return $sformatf("kind %0d byte %02h seg %0d part %0d found %0d last %0d",
            r.kind, r.out_byte, r.segment, r.part_number, r.parts_found, r.last_result);
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic logic [5:0] pat_len();
        logic [5:0] l;
        l = bnd_len;
        if (l == 6'd0) l = 6'd1;
        if (l > 6'd32) l = 6'd32;
        return 6'(l + 6'd2);
    endfunction

    function automatic logic [7:0] pat_at(input logic [5:0] k);
        int i;
        i = int'(k) - 2;
        if (k < 6'd2) return CH_DASH;
        if (i >= 32) return 8'h00;
        return bnd_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic logic [1:0] seg_now();
        if (pm == PM_SKIP_END || pm == PM_EPILOGUE) return SEG_EPI;
        return (parts != 8'd0) ? SEG_PART : SEG_PRE;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] b);
        t_out r;
        r.kind        = kind;
        r.out_byte    = (kind == KIND_CONTENT) ? b : 8'h00;
        r.segment     = seg_now();
        r.part_number = parts;
        r.parts_found = (kind == KIND_DONE) && (parts != 8'd0);
        r.last_result = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void flush_held();
        for (int k = 0; k < int'(held); k++) emit(KIND_CONTENT, pat_at(6'(k)));
        if (held != 6'd0 && pat_at(6'(held - 6'd1)) == CH_NL) ls = 1'b1;
        held = 6'd0;
    endfunction

    function automatic void start_part();
        if (parts != 8'd255) parts++;
        pm   = PM_BODY;
        held = 6'd0;
        ls   = 1'b1;
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        logic [5:0] pl;
        pl = pat_len();
        if (held >= pl) held = 6'(pl - 6'd1);
        if (held != 6'd0) begin
            if (c == pat_at(held)) begin
                held++;
                if (held == pl) begin
                    held = 6'd0;
                    if (pm == PM_BODY) emit(KIND_CLOSE, 8'h00);
                    pm = PM_POST1;
                end
                return;
            end
            ls = 1'b0;
            flush_held();
        end
        if (ls && c == pat_at(6'd0)) begin
            held = 6'd1;
            ls   = 1'b0;
            return;
        end
        emit(KIND_CONTENT, c);
        ls = (c == CH_NL);
    endfunction

    function automatic void predict_word(input logic [7:0] c, input logic eom);
        step_res.delete();
        case (pm)
            PM_PRE, PM_BODY: scan_byte(c);
            PM_POST1: begin
                if (c == CH_DASH) pm = PM_POST2;
                else if (c == CH_NL) start_part();
                else pm = PM_SKIP;
            end
            PM_POST2: begin
                if (c == CH_DASH) pm = (parts != 8'd0) ? PM_SKIP_END : PM_GIVEN_UP;
                else if (c == CH_NL) start_part();
                else pm = PM_SKIP;
            end
            PM_SKIP: begin
                if (c == CH_NL) start_part();
            end
            PM_SKIP_END: begin
                if (c == CH_NL) pm = PM_EPILOGUE;
            end
            PM_EPILOGUE: emit(KIND_CONTENT, c);
            default: ;
        endcase
        if (eom) begin
            if (pm == PM_PRE || pm == PM_BODY) begin
                if (held >= pat_len()) held = 6'(pat_len() - 6'd1);
                flush_held();
            end
            emit(KIND_DONE, 8'h00);
            pm    = PM_PRE;
            held  = 6'd0;
            ls    = 1'b1;
            parts = 8'd0;
        end
        if (step_res.size() > 0) step_res[step_res.size() - 1].last_result = 1'b1;
        foreach (step_res[i]) pending_results.push_back(step_res[i]);
    endfunction

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch({"result with nothing pending: ", fmt_result(o_out_data)});
            end else begin
                want = pending_results.pop_front();
                bad_fields = "";
                if (o_out_data.kind !== want.kind) bad_fields = {bad_fields, " kind"};
                if (o_out_data.out_byte !== want.out_byte) bad_fields = {bad_fields, " byte"};
                if (o_out_data.segment !== want.segment) bad_fields = {bad_fields, " segment"};
                if (o_out_data.part_number !== want.part_number)
                    bad_fields = {bad_fields, " part"};
                if (o_out_data.parts_found !== want.parts_found)
                    bad_fields = {bad_fields, " found"};
                if (o_out_data.last_result !== want.last_result)
                    bad_fields = {bad_fields, " last"};
                if (bad_fields != "")
                    report_mismatch($sformatf("result %0d bad%s: got %s, want %s",
                        results_checked, bad_fields, fmt_result(o_out_data),
                        fmt_result(want)));
            end
            results_checked++;
        end
    end

    // output stall bursts
    initial begin : out_pacing
        int  n;
        logic v;
        forever begin
            if (quiet || !idle_on) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 15);
                v = ($urandom_range(0, 2) == 0);
                repeat (n) begin
                    i_out_stall <= v;
                    @(posedge i_clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_word(input logic [7:0] b, input logic eom);
        t_in w;
        int  gap;
        gap = 0;
        if (!quiet && idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.in_byte        = b;
        w.end_of_message = eom;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_word(b, eom);
        words_sent++;
        if (eom) msgs_done++;
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg_q.size(); i++)
            send_word(msg_q[i], msg_eom && (i == msg_q.size() - 1));
    endtask

    // lets every pending result drain before touching registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_LENGTH: bnd_len     = d[5:0];
            CFG_WORD0:  bnd_word[0] = d;
            CFG_WORD1:  bnd_word[1] = d;
            CFG_WORD2:  bnd_word[2] = d;
            CFG_WORD3:  bnd_word[3] = d;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic program_boundary(input logic [5:0] len_sel);
        logic [63:0] d;
        d = {32'($urandom), 32'($urandom)};
        d[5:0] = len_sel;
        cfg_write(CFG_LENGTH, d);
        cfg_write(CFG_WORD0, cfg_words[0]);
        cfg_write(CFG_WORD1, cfg_words[1]);
        cfg_write(CFG_WORD2, cfg_words[2]);
        cfg_write(CFG_WORD3, cfg_words[3]);
        i_cfg_valid <= 1'b0;
        bnd_q.delete();
        for (int k = 2; k < int'(pat_len()); k++) bnd_q.push_back(pat_at(6'(k)));
        settings_used++;
    endtask

    // ---------------------------------------------------------------- message builders

    function automatic void make_boundary(input int eff);
        logic [7:0] b;
        for (int i = 0; i < 32; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i < eff) begin
                case ($urandom_range(0, 5))
                    0, 1, 2: b = 8'h61 + 8'($urandom_range(0, 2));
                    3:       b = CH_DASH;
                    4:       b = CH_NL;
                    default: ;
                endcase
            end
            cfg_words[i / 8][(i % 8) * 8 +: 8] = b;
        end
    endfunction

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'h61 + 8'($urandom_range(0, 2));
            4:          return CH_DASH;
            5:          return bnd_q[$urandom_range(0, bnd_q.size() - 1)];
            6:          return CH_NL;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    endfunction

    function automatic void add_line();
        int k;
        int n;
        // sometimes a line opens with a false start of the pattern
        if ($urandom_range(0, 3) == 0) begin
            msg_q.push_back(CH_DASH);
            if ($urandom_range(0, 1) == 1) begin
                msg_q.push_back(CH_DASH);
                k = $urandom_range(0, bnd_q.size() - 1);
                for (int i = 0; i < k; i++) msg_q.push_back(bnd_q[i]);
            end
        end
        n = $urandom_range(0, 5);
        repeat (n) msg_q.push_back(text_byte());
        msg_q.push_back(CH_NL);
    endfunction

    function automatic void add_boundary(input bit closing);
        msg_q.push_back(CH_DASH);
        msg_q.push_back(CH_DASH);
        foreach (bnd_q[i]) msg_q.push_back(bnd_q[i]);
        if (closing) begin
            msg_q.push_back(CH_DASH);
            msg_q.push_back(CH_DASH);
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) msg_q.push_back(text_byte());
        if ($urandom_range(0, 9) != 0) msg_q.push_back(CH_NL);
    endfunction

    function automatic void build_message(input int eff);
        int sel;
        int n;
        int cut;
        msg_q.delete();
        msg_eom = 1'b1;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            n = $urandom_range(1, 10);
            repeat (n) msg_q.push_back($urandom_range(0, 1) ? text_byte()
                                                              : 8'($urandom_range(0, 255)));
            msg_eom = 1'($urandom_range(0, 1));
        end else begin
            repeat ($urandom_range(0, 2)) add_line();
            n = $urandom_range(0, (eff > 8) ? 1 : 3);
            repeat (n) begin
                add_boundary(1'b0);
                repeat ($urandom_range(0, 2)) add_line();
            end
            add_boundary(1'b1);
            repeat ($urandom_range(0, 2)) add_line();
            if (sel == 1) begin
                cut = $urandom_range(1, msg_q.size());
                while (msg_q.size() > cut) void'(msg_q.pop_back());
            end
        end
        if (msg_q.size() == 0) msg_q.push_back(text_byte());
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic use_short_boundary(input logic [5:0] len_sel, input string s);
        wait_idle();
        make_boundary(0);
        for (int i = 0; i < s.len(); i++) cfg_words[0][i * 8 +: 8] = s[i];
        program_boundary(len_sel);
    endtask

    task automatic test_basic_parts();
        use_short_boundary(6'd1, "b");
        msg_q.delete();
        msg_eom = 1'b1;
        add_text("--b\n");
        msg_q.push_back(8'hff);
        add_text("\n--b--\n");
        msg_q.push_back(8'h00);
        send_msg();
    endtask

    task automatic test_end_boundary_first();
        msg_q.delete();
        msg_eom = 1'b1;
        add_text("--b--Z");
        send_msg();
    endtask

    task automatic test_held_flush();
        msg_q.delete();
        msg_eom = 1'b1;
        add_text("--x\n-");
        send_msg();
    endtask

    task automatic test_config_mid_match();
        use_short_boundary(6'd3, "abc");
        msg_q.delete();
        msg_eom = 1'b0;
        add_text("--ab");
        send_msg();
        use_short_boundary(6'd1, "abc");
        msg_q.delete();
        msg_eom = 1'b1;
        add_text("z");
        send_msg();
    endtask

    task automatic test_random_messages();
        int         phase;
        int         eff;
        int         start;
        int         phase_start;
        logic [5:0] len_sel;
        phase = 0;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            wait_idle();
            case (phase)
                0:       len_sel = 6'd0;
                1:       len_sel = 6'd63;
                2:       len_sel = 6'd32;
                default: begin
                    case ($urandom_range(0, 9))
                        7:       len_sel = 6'($urandom_range(5, 12));
                        8:       len_sel = 6'($urandom_range(33, 62));
                        9:       len_sel = 6'd1;
                        default: len_sel = 6'($urandom_range(1, 4));
                    endcase
                end
            endcase
            eff = (len_sel == 6'd0) ? 1 : ((len_sel > 6'd32) ? 32 : int'(len_sel));
            make_boundary(eff);
            program_boundary(len_sel);
            idle_on = ($urandom_range(0, 3) != 0);
            phase_start = words_sent;
            do begin
                quiet = (words_sent - start) >= QUIET_FROM;
                build_message(eff);
                send_msg();
            end while (eff <= 8 && words_sent - phase_start < 50 &&
                       words_sent - start < RANDOM_WORDS);
            phase++;
        end
    endtask

    initial begin
        int waited;
        pm      = PM_PRE;
        held    = 6'd0;
        ls      = 1'b1;
        parts   = 8'd0;
        bnd_len = 6'd1;
        foreach (bnd_word[i]) bnd_word[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_parts();
        test_end_boundary_first();
        test_held_flush();
        test_config_mid_match();
        test_random_messages();

        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < END_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("sent %0d words in %0d finished messages, checked %0d results",
            words_sent, msgs_done, results_checked);
        $display("made %0d register writes over %0d boundary settings",
            cfg_writes, settings_used);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
design/mmsp_pkg.sv
design/mmsp_front.sv
design/mmsp_queue.sv
design/mmsp_back.sv
design/mime_multipart_splitter_top.sv
design/mmsp_checker.sv
dv/mime_multipart_splitter_top_test.sv
